>>> rtl/wrrs_pkg.sv
// ----------------------------------------------------------------------------
// wrrs_pkg: shared types for the weighted round-robin scheduler
// Microcode word layout, sequencer condition codes, result action codes and
// the control program itself.
// ----------------------------------------------------------------------------
`default_nettype none

package wrrs_pkg;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_SEND   = 2'd0,
    ACT_QUEUED = 2'd1,
    ACT_REJECT = 2'd2,
    ACT_IDLE   = 2'd3
  } act_t;

  // Event kinds on the input tuser
  localparam logic EV_ARRIVAL = 1'b0;
  localparam logic EV_FINISH  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_WEIGHT_Q0    = 3'd0;
  localparam logic [2:0] REG_WEIGHT_Q1    = 3'd1;
  localparam logic [2:0] REG_WEIGHT_Q2    = 3'd2;
  localparam logic [2:0] REG_WEIGHT_Q3    = 3'd3;
  localparam logic [2:0] REG_BUFFER_LIMIT = 3'd4;

  localparam int NumWeights = 4;

  // Datapath operation carried by each control word
  typedef enum logic [1:0] {
    OP_ACCEPT = 2'd0,
    OP_EVENT  = 2'd1,
    OP_LOOK   = 2'd2,
    OP_EMIT   = 2'd3
  } op_t;

  // Branch condition tested at the end of each step
  typedef enum logic [1:0] {
    COND_IN_VALID   = 2'd0,
    COND_NEED_LOOK  = 2'd1,
    COND_LOOK_AGAIN = 2'd2,
    COND_OUT_FREE   = 2'd3
  } cond_t;

  typedef logic [1:0] step_t;

  // Program step addresses
  localparam step_t STEP_ACCEPT = 2'd0;
  localparam step_t STEP_EVENT  = 2'd1;
  localparam step_t STEP_LOOK   = 2'd2;
  localparam step_t STEP_EMIT   = 2'd3;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ucode_t;

  // Condition flags from the datapath into the sequencer
  typedef struct packed {
    logic in_valid;
    logic need_look;
    logic look_again;
    logic out_free;
  } flags_t;

  // Control program
  function automatic ucode_t ucode_rom(input step_t addr);
    ucode_t w;
    unique case (addr)
      STEP_ACCEPT: w = '{OP_ACCEPT, COND_IN_VALID,   STEP_EVENT,  STEP_ACCEPT};
      STEP_EVENT:  w = '{OP_EVENT,  COND_NEED_LOOK,  STEP_LOOK,   STEP_EMIT};
      STEP_LOOK:   w = '{OP_LOOK,   COND_LOOK_AGAIN, STEP_LOOK,   STEP_EMIT};
      STEP_EMIT:   w = '{OP_EMIT,   COND_OUT_FREE,   STEP_ACCEPT, STEP_EMIT};
      default:     w = '{OP_ACCEPT, COND_IN_VALID,   STEP_EVENT,  STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/wrrs_seq.sv
// ----------------------------------------------------------------------------
// wrrs_seq: microcode sequencer
// Holds the step counter, reads the control word from the program table and
// branches on the condition flag selected by that word.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrs_seq (
  input  wire                   clk,
  input  wire                   rst,
  input  wire wrrs_pkg::flags_t flags,
  output wrrs_pkg::ucode_t      ctrl
);

  wrrs_pkg::step_t step;
  wrrs_pkg::step_t step_next;
  logic            taken;

  // Fetch the current control word
  assign ctrl = wrrs_pkg::ucode_rom(step);

  // Select the branch condition
  always_comb begin
    unique case (ctrl.cond)
      wrrs_pkg::COND_IN_VALID:   taken = flags.in_valid;
      wrrs_pkg::COND_NEED_LOOK:  taken = flags.need_look;
      wrrs_pkg::COND_LOOK_AGAIN: taken = flags.look_again;
      wrrs_pkg::COND_OUT_FREE:   taken = flags.out_free;
      default:                   taken = 1'b0;
    endcase
    step_next = taken ? ctrl.tgt_true : ctrl.tgt_false;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= wrrs_pkg::STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/weighted_round_robin_packet_scheduler_unit.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_packet_scheduler_unit: WRR link scheduler
// Decides, per event, whether a packet starts sending, is queued or is
// rejected, and which queue the link serves next.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transaction: tuser is the event kind
//   (arrival or transmission finished), tdata the arriving packet's queue.
//   m_axis returns exactly one result per event: tuser is the action,
//   tdata the queue that starts sending and the bypass flag.
//   cfg writes weights and the buffer limit; write only while idle.
//   A small microcoded sequencer runs each event: accept, decode, zero to
//   NUM_QUEUES+1 queue looks (one per cycle), then load the output register.
//   An arrival or a finish on an idle link goes from acceptance straight to
//   the output register; a finish on a busy link first runs the looks of the
//   rotation loop. The next event is accepted once the result is loaded, so
//   the unit handles one event at a time.
//   Reset sets all weights to 1, the limit to 64, empties the queue counts
//   and idles the link. When the receiver stalls, one result waits in the
//   output register while the next event is processed; the sequencer then
//   holds in its emit step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_round_robin_packet_scheduler_unit #(
  parameter int NUM_QUEUES = 4
) (
  input  wire        clk,
  input  wire        rst,
  // Events
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [7:0]  s_axis_tdata,   // [1:0] queue_id, [7:2] zero
  input  wire        s_axis_tuser,   // [0] func
  // Results
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] send_queue, [2] bypassed, [7:3] zero
  output logic [1:0] m_axis_tuser,   // [1:0] action
  // Configuration writes
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [2:0]  cfg_index,
  input  wire [7:0]  cfg_data
);

  localparam int QW = (NUM_QUEUES > 2) ? 2 : 1;
  localparam logic [2:0] LOOK_LIMIT = 3'(NUM_QUEUES + 1);
  localparam logic [QW-1:0] LAST_Q = QW'(NUM_QUEUES - 1);

  wrrs_pkg::ucode_t ctrl;
  wrrs_pkg::flags_t flags;

  // Configuration
  logic [7:0] weight [wrrs_pkg::NumWeights];
  logic [7:0] buffer_limit;

  // Scheduler state
  logic          link_busy;
  logic [QW-1:0] active_queue;
  logic [7:0]    served_in_turn;
  logic [2:0]    empty_looks;
  logic [7:0]    queue_fill [NUM_QUEUES];

  // Latched event
  logic       ev_func;
  logic [1:0] ev_qid;

  // Pending result and output register
  wrrs_pkg::act_t res_action;
  logic [1:0]     res_queue;
  logic           res_byp;
  logic           out_valid;
  wrrs_pkg::act_t out_action;
  logic [1:0]     out_queue;
  logic           out_byp;

  // Datapath terms
  logic [QW-1:0] rd_idx;
  logic [7:0]    fill_rd;
  logic          qid_ok;
  logic          eligible;
  logic [2:0]    looks_inc;
  logic          looks_done;
  logic [QW-1:0] next_queue;
  logic          in_accept;
  logic          out_free;

  wrrs_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Handshakes
  assign s_axis_tready = (ctrl.op == wrrs_pkg::OP_ACCEPT);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;

  // One fill read port: arrival queue while decoding, active queue otherwise
  assign rd_idx  = (ctrl.op == wrrs_pkg::OP_EVENT) ? ev_qid[QW-1:0] : active_queue;
  assign fill_rd = queue_fill[rd_idx];

  assign qid_ok     = (int'(ev_qid) < NUM_QUEUES);
  assign eligible   = (served_in_turn < weight[active_queue]) && (fill_rd != 8'd0);
  assign looks_inc  = empty_looks + 3'd1;
  assign looks_done = (looks_inc >= LOOK_LIMIT);
  assign next_queue = (active_queue == LAST_Q) ? '0 : active_queue + QW'(1);

  // Branch flags for the sequencer
  always_comb begin
    flags.in_valid   = s_axis_tvalid;
    flags.need_look  = (ev_func == wrrs_pkg::EV_FINISH) && link_busy;
    flags.look_again = !eligible && !looks_done;
    flags.out_free   = out_free;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wrrs_pkg::NumWeights; i++) begin
        weight[i] <= 8'd1;
      end
      buffer_limit <= 8'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wrrs_pkg::REG_WEIGHT_Q0:    weight[0] <= cfg_data;
        wrrs_pkg::REG_WEIGHT_Q1:    weight[1] <= cfg_data;
        wrrs_pkg::REG_WEIGHT_Q2:    weight[2] <= cfg_data;
        wrrs_pkg::REG_WEIGHT_Q3:    weight[3] <= cfg_data;
        wrrs_pkg::REG_BUFFER_LIMIT: buffer_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the accepted event
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ev_func <= s_axis_tuser;
      ev_qid  <= s_axis_tdata[1:0];
    end
  end

  // Scheduler state and pending result, driven by the current step
  always_ff @(posedge clk) begin
    if (rst) begin
      link_busy      <= 1'b0;
      active_queue   <= '0;
      served_in_turn <= 8'd0;
      empty_looks    <= 3'd0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        queue_fill[i] <= 8'd0;
      end
    end else begin
      unique case (ctrl.op)
        wrrs_pkg::OP_EVENT: begin
          if (ev_func == wrrs_pkg::EV_ARRIVAL) begin
            if (!qid_ok) begin
              res_action <= wrrs_pkg::ACT_REJECT;
              res_queue  <= 2'd0;
              res_byp    <= 1'b0;
            end else if (!link_busy) begin
              // Start sending at once, bypassing the queue
              link_busy      <= 1'b1;
              active_queue   <= ev_qid[QW-1:0];
              served_in_turn <= 8'd1;
              res_action     <= wrrs_pkg::ACT_SEND;
              res_queue      <= ev_qid;
              res_byp        <= 1'b1;
            end else if (fill_rd >= buffer_limit) begin
              res_action <= wrrs_pkg::ACT_REJECT;
              res_queue  <= 2'd0;
              res_byp    <= 1'b0;
            end else begin
              queue_fill[rd_idx] <= fill_rd + 8'd1;
              res_action         <= wrrs_pkg::ACT_QUEUED;
              res_queue          <= 2'd0;
              res_byp            <= 1'b0;
            end
          end else begin
            // Finish on an idle link reports idle; a busy link goes to the looks
            res_action <= wrrs_pkg::ACT_IDLE;
            res_queue  <= 2'd0;
            res_byp    <= 1'b0;
          end
        end
        wrrs_pkg::OP_LOOK: begin
          res_byp <= 1'b0;
          if (eligible) begin
            queue_fill[rd_idx] <= fill_rd - 8'd1;
            served_in_turn     <= served_in_turn + 8'd1;
            empty_looks        <= 3'd0;
            res_action         <= wrrs_pkg::ACT_SEND;
            res_queue          <= 2'(active_queue);
          end else if (looks_done) begin
            empty_looks <= 3'd0;
            link_busy   <= 1'b0;
            res_action  <= wrrs_pkg::ACT_IDLE;
            res_queue   <= 2'd0;
          end else begin
            // Rotate to the next queue and open a fresh turn
            empty_looks    <= looks_inc;
            served_in_turn <= 8'd0;
            active_queue   <= next_queue;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load in the emit step, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.op == wrrs_pkg::OP_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == wrrs_pkg::OP_EMIT) && out_free) begin
      out_action <= res_action;
      out_queue  <= res_queue;
      out_byp    <= res_byp;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_action;
  assign m_axis_tdata  = {5'd0, out_byp, out_queue};

endmodule

`default_nettype wire
